/* sv/weighted_normalized_distance_assert.svh */
// Assertion macros for the weighted normalized distance port checker.
`ifndef WEIGHTED_NORMALIZED_DISTANCE_ASSERT_SVH
`define WEIGHTED_NORMALIZED_DISTANCE_ASSERT_SVH

// Property checked only outside reset.
`define WND_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, including while reset is high.
`define WND_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/wnd_pkg.sv */
// Package with shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
package wnd_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int WEIGHT_W       = 18;
  localparam int QUOT_W         = 32;
  localparam int ONE_Q16        = 65536;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_sq;
    logic mul_lo;
    logic mul_hi;
    logic mk_term;
    logic acc;
    logic sqrt_init;
    logic sqrt_step;
    logic publish;
  } wnd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero;
    logic sat;
    logic last;
    logic out_busy;
  } wnd_status_t;

endpackage

/* sv/wnd_ctrl.sv */
// Controller state machine sequencing divide, multiply, accumulate and square root.
`timescale 1ns / 1ps
module wnd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wnd_pkg::wnd_status_t status,
  output wnd_pkg::wnd_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_LO   = 4'd4;
  localparam logic [3:0] S_HI   = 4'd5;
  localparam logic [3:0] S_TERM = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  // Next state, step counter and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (status.zero) begin
          state_next = S_FIN;
        end else if (status.sat) begin
          state_next = S_SQ;
        end else begin
          cnt_next   = 5'd31;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 5'd1;
        if (cnt == 5'd0) state_next = S_SQ;
      end
      S_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = S_LO;
      end
      S_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_HI;
      end
      S_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_TERM;
      end
      S_TERM: begin
        cmd.mk_term = 1'b1;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (status.last) begin
          cmd.sqrt_init = 1'b1;
          cnt_next      = 5'd31;
          state_next    = S_SQRT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt - 5'd1;
        if (cnt == 5'd0) state_next = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

/* sv/wnd_datapath.sv */
// Datapath: divider, shared multiplier, accumulators, square root and output register.
`timescale 1ns / 1ps
module wnd_datapath #(
  parameter int DATA_WIDTH = wnd_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wnd_pkg::wnd_cmd_t             cmd,
  output wnd_pkg::wnd_status_t          status,
  input  logic signed [DATA_WIDTH-1:0]  coord_a,
  input  logic signed [DATA_WIDTH-1:0]  coord_b,
  input  logic signed [wnd_pkg::WEIGHT_W-1:0] weight,
  input  logic signed [DATA_WIDTH-1:0]  range_upper,
  input  logic signed [DATA_WIDTH-1:0]  range_lower,
  input  logic                          last_element,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   distance,
  output logic                          weight_out_of_range,
  output logic                          weight_sum_exceeded,
  output logic                          zero_range,
  output logic                          saturated
);

  localparam int MW = DATA_WIDTH + 1;   // magnitude width
  localparam int RW = DATA_WIDTH + 2;   // divider remainder width
  localparam int XW = DATA_WIDTH + 17;  // saturation compare width

  // Operand preparation at load.
  logic signed [MW-1:0] diff, width;
  logic [MW-1:0]        n_mag, d_mag;
  logic                 zero_c, sat_c, wbad_c;
  logic [16:0]          wc_c;
  logic signed [32:0]   wsum33;
  logic [31:0]          wtot_next;

  assign diff   = MW'(coord_a) - MW'(coord_b);
  assign width  = MW'(range_upper) - MW'(range_lower);
  assign n_mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);
  assign d_mag  = width[MW-1] ? MW'(-width) : MW'(width);
  assign zero_c = (range_upper == range_lower);
  assign sat_c  = XW'(n_mag) >= {d_mag, 16'b0};
  assign wbad_c = weight[17] || (weight[16:0] > 17'(wnd_pkg::ONE_Q16));
  assign wc_c   = weight[17] ? 17'd0 :
                  (weight[16:0] > 17'(wnd_pkg::ONE_Q16)) ? 17'(wnd_pkg::ONE_Q16) :
                  weight[16:0];

  // Saturating running weight sum.
  logic signed [31:0] wtot;
  assign wsum33 = 33'(wtot) + 33'(weight);
  assign wtot_next = (wsum33[32] != wsum33[31]) ?
                     (wsum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : wsum33[31:0];

  // Element registers.
  logic [MW-1:0] d_r;
  logic [RW-1:0] rem;
  logic [31:0]   nshift;
  logic [31:0]   q;
  logic [16:0]   wc;
  logic          zero_r, sat_r, last_r;

  // Divider step.
  logic [RW-1:0] rem_sh;
  logic          ge;
  assign rem_sh = {rem[RW-2:0], nshift[31]};
  assign ge     = rem_sh >= RW'(d_r);

  // Shared multiplier.
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [63:0] sq;
  logic [48:0] p_lo, p_hi;
  assign op_a = cmd.mul_sq ? q : (cmd.mul_hi ? sq[63:32] : sq[31:0]);
  assign op_b = cmd.mul_sq ? q : 32'(wc);
  assign prod = op_a * op_b;

  // Term and accumulation.
  logic [64:0] term_full, acc_full;
  logic [63:0] term, wsum;
  logic [3:0]  err;
  assign term_full = {p_hi, 16'b0} + 65'(p_lo[48:16]);
  assign acc_full  = {1'b0, wsum} + {1'b0, term};

  // Square root step, two radicand bits per cycle.
  logic [63:0] sv;
  logic [31:0] root;
  logic [33:0] srem, srem_sh, trial;
  logic [3:0]  snap;
  assign srem_sh = {srem[31:0], sv[63:62]};
  assign trial   = {root, 2'b01};

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r    <= d_mag;
      rem    <= RW'(n_mag >> 16);
      nshift <= {n_mag[15:0], 16'b0};
      q      <= sat_c ? 32'hFFFF_FFFF : 32'h0;
      wc     <= wc_c;
      zero_r <= zero_c;
      sat_r  <= sat_c;
      last_r <= last_element;
    end
    if (cmd.div_step) begin
      rem    <= ge ? (rem_sh - RW'(d_r)) : rem_sh;
      q      <= {q[30:0], ge};
      nshift <= {nshift[30:0], 1'b0};
    end
    if (cmd.mul_sq) sq <= prod;
    if (cmd.mul_lo) p_lo <= prod[48:0];
    if (cmd.mul_hi) p_hi <= prod[48:0];
    if (cmd.mk_term) term <= term_full[63:0];
    if (cmd.sqrt_init) begin
      sv   <= wsum;
      root <= '0;
      srem <= '0;
      snap <= {err[3] | (wtot > 32'sd65536), err[2:0]};
    end
    if (cmd.sqrt_step) begin
      sv <= {sv[61:0], 2'b00};
      if (srem_sh >= trial) begin
        srem <= srem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        srem <= srem_sh;
        root <= {root[30:0], 1'b0};
      end
    end
    if (cmd.publish) begin
      distance            <= root;
      weight_out_of_range <= snap[0];
      zero_range          <= snap[1];
      saturated           <= snap[2];
      weight_sum_exceeded <= snap[3];
    end
  end

  // Accumulated state, cleared by reset and after each vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      wsum <= '0;
      wtot <= '0;
      err  <= '0;
    end else if (cmd.sqrt_init) begin
      wsum <= '0;
      wtot <= '0;
      err  <= '0;
    end else begin
      if (cmd.load) begin
        wtot <= wtot_next;
        err  <= err | {1'b0, sat_c & ~zero_c, zero_c, wbad_c};
      end
      if (cmd.acc) begin
        if (acc_full[64]) begin
          wsum   <= '1;
          err[2] <= 1'b1;
        end else begin
          wsum <= acc_full[63:0];
        end
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.zero     = zero_r;
  assign status.sat      = sat_r;
  assign status.last     = last_r;
  assign status.out_busy = out_valid & ~out_ready;

endmodule

/* sv/weighted_normalized_distance.sv */
// Top level of the weighted, range-normalized Euclidean distance block.
// Usage:
//   Input channel (in_valid/in_ready) carries one vector element per beat:
//   two coordinates, a weight and the range bounds, plus last_element.
//   Output channel (out_valid/out_ready) carries one beat per vector, sent
//   after the element marked last: distance and four sticky error flags.
// Work per element, from accept to ready again:
//   zero range width: no arithmetic; saturated quotient: the divider is skipped;
//   otherwise the 32-step restoring divider (one quotient bit per cycle), the
//   square, low and high products on the shared 32x32 multiplier, then the
//   term and the accumulation.
//   The last element adds the radix-4 square root (two bits per cycle)
//   and the hand-off to the output register.
// The result sits in an output register; the next vector is taken while it
// waits. If the receiver still holds a result when the next one is finished,
// the block waits with in_ready low until the beat is taken.
// Reset (rst, synchronous) clears the sums, the internal error flags and out_valid.
`timescale 1ns / 1ps
module weighted_normalized_distance #(
  parameter int DATA_WIDTH = wnd_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  coord_a,
  input  logic signed [DATA_WIDTH-1:0]  coord_b,
  input  logic signed [wnd_pkg::WEIGHT_W-1:0] weight,
  input  logic signed [DATA_WIDTH-1:0]  range_upper,
  input  logic signed [DATA_WIDTH-1:0]  range_lower,
  input  logic                          last_element,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   distance,
  output logic                          weight_out_of_range,
  output logic                          weight_sum_exceeded,
  output logic                          zero_range,
  output logic                          saturated
);

  wnd_pkg::wnd_cmd_t    cmd;
  wnd_pkg::wnd_status_t status;

  // Sequencer.
  wnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  wnd_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .coord_a             (coord_a),
    .coord_b             (coord_b),
    .weight              (weight),
    .range_upper         (range_upper),
    .range_lower         (range_lower),
    .last_element        (last_element),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .distance            (distance),
    .weight_out_of_range (weight_out_of_range),
    .weight_sum_exceeded (weight_sum_exceeded),
    .zero_range          (zero_range),
    .saturated           (saturated)
  );

endmodule

/* sv/wnd_checker.sv */
// Port-level assertion checker for the distance block, with its bind.
`timescale 1ns / 1ps
`include "weighted_normalized_distance_assert.svh"
module wnd_checker #(
  parameter int DATA_WIDTH = wnd_pkg::DATA_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [DATA_WIDTH-1:0]  coord_a,
  input logic signed [DATA_WIDTH-1:0]  coord_b,
  input logic signed [wnd_pkg::WEIGHT_W-1:0] weight,
  input logic signed [DATA_WIDTH-1:0]  range_upper,
  input logic signed [DATA_WIDTH-1:0]  range_lower,
  input logic                          last_element,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [31:0]                   distance,
  input logic                          weight_out_of_range,
  input logic                          weight_sum_exceeded,
  input logic                          zero_range,
  input logic                          saturated
);

  // A stalled result beat keeps its value.
  `WND_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(distance), "result changed while stalled")
  // An accepted element keeps the input side busy for the next cycle.
  `WND_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready right after accept")
  // A new result is raised only out of a state in which no element could be taken.
  `WND_ASSERT(a_result_after_work, $rose(out_valid) |-> !$past(in_ready), "result without work")
  // Reset empties the output register.
  `WND_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "out_valid after reset")

endmodule

bind weighted_normalized_distance wnd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_wnd_checker (.*);

/* tb/sv/weighted_normalized_distance_checker.sv */
// Checker that predicts and compares the distance results of the block.
`timescale 1ns / 1ps
module weighted_normalized_distance_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  coord_a,
  input  logic signed [DATA_WIDTH-1:0]  coord_b,
  input  logic signed [wnd_pkg::WEIGHT_W-1:0] weight,
  input  logic signed [DATA_WIDTH-1:0]  range_upper,
  input  logic signed [DATA_WIDTH-1:0]  range_lower,
  input  logic                          last_element,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [31:0]                   distance,
  input  logic                          weight_out_of_range,
  input  logic                          weight_sum_exceeded,
  input  logic                          zero_range,
  input  logic                          saturated,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic [31:0] dist_val;
    logic        wrange;
    logic        wsum;
    logic        zrange;
    logic        sat;
  } dist_result_t;

  localparam longint ONE = wnd_pkg::ONE_Q16;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  // Running state of the vector in progress.
  logic [63:0]  acc_sum;
  longint       acc_weight;
  logic         f_wrange, f_zero, f_sat, f_wsum;
  dist_result_t expected_q[$];

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [31:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // Fold one accepted element into the running state; queue the result on last.
  task automatic absorb_element();
    longint a, b, w, wc, up, lo;
    logic [63:0] num, den, ip, rem, sq, term;
    logic [31:0] q, frac;
    dist_result_t r;
    a = coord_a; b = coord_b; w = weight; up = range_upper; lo = range_lower;
    wc = w;
    if (w < 0 || w > ONE) f_wrange = 1;
    if (wc < 0) wc = 0;
    if (wc > ONE) wc = ONE;
    acc_weight = acc_weight + w;
    if (acc_weight > I32_MAX) acc_weight = I32_MAX;
    if (acc_weight < I32_MIN) acc_weight = I32_MIN;
    if (up == lo) begin
      f_zero = 1;
    end else begin
      num = magnitude(a - b);
      den = magnitude(up - lo);
      ip = num / den;
      rem = num % den;
      if (ip >= ONE) begin
        f_sat = 1;
        q = 32'hFFFF_FFFF;
      end else begin
        frac = 0;
        for (int i = 0; i < 16; i++) begin
          rem = rem << 1;
          frac = frac << 1;
          if (rem >= den) begin
            rem = rem - den;
            frac[0] = 1;
          end
        end
        q = {ip[15:0], frac[15:0]};
      end
      sq = 64'(q) * 64'(q);
      term = (sq >> 16) * 64'(wc) + (((sq & 64'hFFFF) * 64'(wc)) >> 16);
      if (acc_sum > ~64'd0 - term) begin
        acc_sum = ~64'd0;
        f_sat = 1;
      end else begin
        acc_sum = acc_sum + term;
      end
    end
    if (last_element) begin
      if (acc_weight > ONE) f_wsum = 1;
      r.dist_val = root_floor(acc_sum);
      r.wrange = f_wrange;
      r.wsum = f_wsum;
      r.zrange = f_zero;
      r.sat = f_sat;
      expected_q.push_back(r);
      acc_sum = 0; acc_weight = 0;
      f_wrange = 0; f_zero = 0; f_sat = 0; f_wsum = 0;
    end
  endtask

  // Compare one output beat with the oldest expectation.
  task automatic compare_result();
    dist_result_t e;
    dist_result_t got;
    got = '{distance, weight_out_of_range, weight_sum_exceeded, zero_range, saturated};
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result beat, actual %p", $time, got);
      fail_count++;
    end else begin
      e = expected_q.pop_front();
      if (e.dist_val !== got.dist_val) begin
        $display("%0t: distance expected %h actual %h", $time, e.dist_val, got.dist_val);
        fail_count++;
      end
      if (e.wrange !== got.wrange) begin
        $display("%0t: weight_out_of_range expected %b actual %b", $time, e.wrange,
                 got.wrange);
        fail_count++;
      end
      if (e.wsum !== got.wsum) begin
        $display("%0t: weight_sum_exceeded expected %b actual %b", $time, e.wsum, got.wsum);
        fail_count++;
      end
      if (e.zrange !== got.zrange) begin
        $display("%0t: zero_range expected %b actual %b", $time, e.zrange, got.zrange);
        fail_count++;
      end
      if (e.sat !== got.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, e.sat, got.sat);
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    acc_sum = 0; acc_weight = 0;
    f_wrange = 0; f_zero = 0; f_sat = 0; f_wsum = 0;
  end

  // Sample both channels at each edge outside reset.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) absorb_element();
    end
    pending = expected_q.size();
  end

endmodule

/* tb/sv/weighted_normalized_distance_test.sv */
// Top of the distance testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module weighted_normalized_distance_test;

  localparam int DW = 32;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic signed [DW-1:0] coord_a = 0, coord_b = 0, range_upper = 0, range_lower = 0;
  logic signed [wnd_pkg::WEIGHT_W-1:0] weight = 0;
  logic                 last_element = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [31:0]          distance;
  logic                 weight_out_of_range, weight_sum_exceeded, zero_range, saturated;
  int                   fail_count;
  int                   pending;

  // Idle percentages for sender and receiver; hold_off forces a long stall.
  int                   send_idle = 0;
  int                   recv_idle = 0;
  bit                   hold_off = 0;

  always #6 clk = ~clk;

  weighted_normalized_distance #(.DATA_WIDTH(DW)) DUT (.*);

  weighted_normalized_distance_checker #(.DATA_WIDTH(DW)) checker_i (.*);

  // Receiver side: random stalls, or a forced hold-off.
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Offer one element and hold it until the beat is taken. Valid stays high
  // after the accept; the next call or drain decides whether it drops.
  task automatic send_element(logic [31:0] a, logic [31:0] b, logic [17:0] w,
                              logic [31:0] up, logic [31:0] lo, bit last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    coord_a <= a; coord_b <= b; weight <= w;
    range_upper <= up; range_lower <= lo; last_element <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(20'hFFFFF)) - 32'sh80000);
      default: return 32'($signed($urandom_range(32'h3FFFF)) - 32'sh20000);
    endcase
  endfunction

  function automatic logic [17:0] rand_weight();
    case ($urandom_range(9))
      0: return 18'($urandom);
      1: return 18'd65536;
      default: return 18'($urandom_range(65536));
    endcase
  endfunction

  // A vector of random elements; mostly well-formed ranges, some zero width.
  task automatic send_vector();
    int n;
    logic [31:0] lo, up, a;
    n = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 5);
    for (int i = 0; i < n; i++) begin
      lo = rand_coord();
      up = ($urandom_range(15) == 0) ? lo : rand_coord();
      a = ($urandom_range(1)) ? lo + 32'($urandom_range(65536 * 4)) : rand_coord();
      send_element(a, rand_coord(), rand_weight(), up, lo, i == n - 1);
    end
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int k;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes and every special case.
    send_element(32'h0001_0000, 32'h0, 18'd65536, 32'h0002_0000, 32'h0, 1);
    send_element(32'h7FFF_FFFF, 32'h8000_0000, 18'd65536, 32'h0000_0001, 32'h0, 1);
    send_element(32'h8000_0000, 32'h7FFF_FFFF, 18'h1FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_element(32'h5, 32'h3, 18'h20000, 32'h0001_0000, 32'h0001_0000, 1);
    send_element(32'h0, 32'h0, 18'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_element(32'hFFFF_FFFF, 32'h0, 18'd40000, 32'h1, 32'h0, 0);
    send_element(32'h0, 32'h0, 18'd40000, 32'h5, 32'h5, 1);
    for (k = 0; k < 6; k++)
      send_element(32'h7FFF_FFFF, 32'h8000_0000, 18'd65536, 32'h1, 32'h0, k == 5);
    send_element(32'h0003_0000, 32'h0001_0000, 18'd32768, 32'h0, 32'h0004_0000, 0);
    send_element(32'h0, 32'h0001_0000, 18'd32768, 32'h0001_0000, 32'h0, 1);
    send_element(32'h1234_5678, 32'hFEDC_BA98, 18'h2AAAA, 32'hFFFF_0000, 32'h0000_FFFF, 1);
    drain();

    // Random phases with different idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 53 : 29) : 0;
      recv_idle = (ph == 2) ? 53 : ((ph == 3) ? 29 : 0);
      for (k = 0; k < 85; k++) send_vector();
    end

    // Long receiver hold-off while elements keep coming.
    send_idle = 0; recv_idle = 0;
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (k = 0; k < 12; k++) send_vector();
        drain();
      end
    join
    for (k = 0; k < 10; k++) send_vector();

    // Final drain, then idle before the verdict.
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("[weighted_normalized_distance] OK");
    else $display("[weighted_normalized_distance] ERROR");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("[weighted_normalized_distance] ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/wnd_pkg.sv
sv/wnd_ctrl.sv
sv/wnd_datapath.sv
sv/weighted_normalized_distance.sv
sv/wnd_checker.sv
tb/sv/weighted_normalized_distance_checker.sv
tb/sv/weighted_normalized_distance_test.sv
